// ===== src/pfb_pkg.sv =====
// shared constants, payload types and palette table for the palette framebuffer scanout
// no dependencies; every other file imports this package
`default_nettype none

package pfb_pkg;

  localparam int FRAME_ROWS  = 240;
  localparam int ROW_BYTES   = 160;
  localparam int FRAME_COLS  = 2 * ROW_BYTES;
  // stores are held as 32-bit words, four pixel bytes each, rows padded to whole words
  localparam int ROW_WORDS   = (ROW_BYTES + 3) / 4;
  localparam int STORE_WORDS = FRAME_ROWS * ROW_WORDS;
  localparam int CHUNKS      = ROW_BYTES / 4;
  localparam int STORE_AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CHUNK_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  // command queue depth, a power of two
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PW     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_CLEAR   = 2'd1;
  localparam logic [1:0] ACT_PRESENT = 2'd2;
  localparam logic [1:0] ACT_RENDER  = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic [3:0] color_index;
    logic [9:0] scan_row;
  } in_t;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic        last_chunk;
  } out_t;

  // classified command handed from the front to the engine
  typedef struct packed {
    logic [1:0]          op;
    logic [STORE_AW-1:0] addr;    // word address of a pixel, or row base for render
    logic [1:0]          lane;    // byte within the word
    logic                nib_hi;  // odd column goes to the high nibble
    logic [3:0]          color;
    logic                oob;     // render row lies outside the frame
  } cmd_t;

  function automatic logic [13:0] palette_color(input logic [3:0] idx);
    logic [13:0] c;
    unique case (idx)
      4'd0:  c = 14'h0000;
      4'd1:  c = 14'h3fff;
      4'd2:  c = 14'h0d11;
      4'd3:  c = 14'h32ef;
      4'd4:  c = 14'h2911;
      4'd5:  c = 14'h12ad;
      4'd6:  c = 14'h28c7;
      4'd7:  c = 14'h1f7a;
      4'd8:  c = 14'h0972;
      4'd9:  c = 14'h010b;
      4'd10: c = 14'h19d7;
      4'd11: c = 14'h154a;
      4'd12: c = 14'h2210;
      4'd13: c = 14'h23b5;
      4'd14: c = 14'h35cf;
      4'd15: c = 14'h2ab5;
      default: c = 14'h0000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/pfb_front.sv =====
// front end: accepts input transfers, drops off-frame pixel writes,
// and turns each item into an engine command with its store address; uses pfb_pkg
`default_nettype none

module pfb_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  pfb_pkg::in_t       in_data,
  input  logic signed [9:0]  offset_y,
  input  logic               init_busy,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output pfb_pkg::cmd_t      cmd
);
  import pfb_pkg::*;

  logic signed [11:0]  row_s;
  logic                row_in;
  logic                px_in;
  logic                py_in;
  logic                keep;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_AW-1:0] row_addr;

  assign row_s  = $signed({2'b00, in_data.scan_row}) - $signed({{2{offset_y[9]}}, offset_y});
  assign row_in = !row_s[11] && (row_s[10:0] < 11'(FRAME_ROWS));

  assign px_in = {1'b0, in_data.pixel_x} < 10'(FRAME_COLS);
  assign py_in = {1'b0, in_data.pixel_y} < 10'(FRAME_ROWS);

  // byte column is x/2, word column is x/8
  assign wr_addr  = STORE_AW'(in_data.pixel_y) * STORE_AW'(ROW_WORDS)
                  + STORE_AW'(in_data.pixel_x[8:3]);
  assign row_addr = STORE_AW'(row_s[8:0]) * STORE_AW'(ROW_WORDS);

  assign keep = (in_data.action != ACT_WRITE) || (px_in && py_in);

  always_comb begin
    cmd.op     = in_data.action;
    cmd.lane   = in_data.pixel_x[2:1];
    cmd.nib_hi = in_data.pixel_x[0];
    cmd.color  = in_data.color_index;
    cmd.oob    = !row_in;
    if (in_data.action == ACT_RENDER) begin
      cmd.addr = row_in ? row_addr : '0;
    end else begin
      cmd.addr = wr_addr;
    end
  end

  // off-frame writes are taken and dropped without a queue entry
  assign in_ready  = cmd_ready && !init_busy;
  assign cmd_valid = in_valid && !init_busy && keep;

endmodule

`default_nettype wire

// ===== src/pfb_cmdq.sv =====
// small command queue between the front end and the engine
// depends on pfb_pkg for the command type and depth
`default_nettype none

module pfb_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pfb_pkg::cmd_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pfb_pkg::cmd_t  pop_data
);
  import pfb_pkg::*;

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wr_ptr_r;
  logic [CMDQ_PW-1:0] rd_ptr_r;
  logic [CMDQ_PW:0]   cnt_r;
  logic               push;
  logic               pop;

  assign push_ready = cnt_r != (CMDQ_PW + 1)'(CMDQ_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = q_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (CMDQ_PW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (CMDQ_PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfb_back.sv =====
// engine: holds the back and front stores and runs pixel writes, clear, present and
// row scanout with a palette-mapped output register; depends on pfb_pkg
`default_nettype none

module pfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pfb_pkg::cmd_t  cmd,
  input  logic [31:0]    sync_word,
  output logic           init_busy,
  output logic           out_valid,
  input  logic           out_ready,
  output pfb_pkg::out_t  out_data
);
  import pfb_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PIX    = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_COPY   = 3'd4;
  localparam logic [2:0] ST_RENDER = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [STORE_AW-1:0] cnt_r, cnt_nxt;
  logic [CHUNK_W-1:0]  chunk_r, chunk_nxt;
  cmd_t                cmd_r;

  logic [31:0]         bk_mem [STORE_WORDS];
  logic [31:0]         fr_mem [STORE_WORDS];
  logic                bk_re, bk_we, fr_re, fr_we;
  logic [STORE_AW-1:0] bk_raddr, bk_waddr, fr_raddr, fr_waddr;
  logic [31:0]         bk_wdata, fr_wdata;
  logic [31:0]         bk_rdata_r, fr_rdata_r;

  logic                cp_valid_r;
  logic [STORE_AW-1:0] cp_addr_r;

  logic                s1_valid_r, s1_last_r, s1_oob_r;
  logic                out_valid_r;
  out_t                out_data_r;
  out_t                out_build;

  logic                cmd_take, cnt_last, chunk_last;
  logic                out_adv, s1_adv, issue;
  logic [31:0]         pix_word;

  assign cmd_ready  = state_r == ST_IDLE;
  assign cmd_take   = cmd_valid && cmd_ready;
  assign init_busy  = state_r == ST_INIT;
  assign cnt_last   = cnt_r == STORE_AW'(STORE_WORDS - 1);
  assign chunk_last = chunk_r == CHUNK_W'(CHUNKS - 1);

  // read data waits in stage one while the output register is held
  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = s1_valid_r && out_adv;
  assign issue   = (state_r == ST_RENDER) && (!s1_valid_r || out_adv);

  // read-modify-write of one nibble; bit offset is lane*8 + nibble*4
  always_comb begin
    pix_word = bk_rdata_r;
    pix_word[{cmd_r.lane, cmd_r.nib_hi, 2'b00} +: 4] = cmd_r.color;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    chunk_nxt = chunk_r;
    bk_re     = 1'b0;
    bk_raddr  = cmd.addr;
    bk_we     = 1'b0;
    bk_waddr  = cnt_r;
    bk_wdata  = '0;
    fr_re     = 1'b0;
    fr_raddr  = cmd_r.addr + STORE_AW'(chunk_r);
    fr_we     = 1'b0;
    fr_waddr  = cnt_r;
    fr_wdata  = '0;
    unique case (state_r)
      ST_INIT: begin
        fr_we   = 1'b1;
        cnt_nxt = cnt_r + STORE_AW'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_take) begin
          cnt_nxt   = '0;
          chunk_nxt = '0;
          unique case (cmd.op)
            ACT_WRITE: begin
              bk_re     = 1'b1;
              state_nxt = ST_PIX;
            end
            ACT_CLEAR:   state_nxt = ST_CLEAR;
            ACT_PRESENT: state_nxt = ST_COPY;
            ACT_RENDER:  state_nxt = ST_RENDER;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX: begin
        bk_we     = 1'b1;
        bk_waddr  = cmd_r.addr;
        bk_wdata  = pix_word;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        bk_we   = 1'b1;
        cnt_nxt = cnt_r + STORE_AW'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_COPY: begin
        bk_re    = 1'b1;
        bk_raddr = cnt_r;
        cnt_nxt  = cnt_r + STORE_AW'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_RENDER: begin
        if (issue) begin
          fr_re     = 1'b1;
          chunk_nxt = chunk_r + CHUNK_W'(1);
          if (chunk_last) begin
            chunk_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // present: the front write lands in the cycle after the back read
    if (cp_valid_r) begin
      fr_we    = 1'b1;
      fr_waddr = cp_addr_r;
      fr_wdata = bk_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      chunk_r     <= '0;
      cp_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      chunk_r    <= chunk_nxt;
      cp_valid_r <= state_r == ST_COPY;
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r <= cmd;
    end
    cp_addr_r <= cnt_r;
    if (issue) begin
      s1_last_r <= chunk_last;
      s1_oob_r  <= cmd_r.oob;
    end
    if (s1_adv) begin
      out_data_r <= out_build;
    end
  end

  always_ff @(posedge clk) begin
    if (bk_we) begin
      bk_mem[bk_waddr] <= bk_wdata;
    end
    if (bk_re) begin
      bk_rdata_r <= bk_mem[bk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      fr_mem[fr_waddr] <= fr_wdata;
    end
    if (fr_re) begin
      fr_rdata_r <= fr_mem[fr_raddr];
    end
  end

  function automatic logic [31:0] pair_word(input logic [7:0] b, input logic [31:0] sync,
                                            input logic oob);
    logic [31:0] v;
    if (oob) begin
      v = sync;
    end else begin
      v = sync | {2'b00, palette_color(b[7:4]), 2'b00, palette_color(b[3:0])};
    end
    return v;
  endfunction

  always_comb begin
    out_build.word0      = pair_word(fr_rdata_r[7:0],   sync_word, s1_oob_r);
    out_build.word1      = pair_word(fr_rdata_r[15:8],  sync_word, s1_oob_r);
    out_build.word2      = pair_word(fr_rdata_r[23:16], sync_word, s1_oob_r);
    out_build.word3      = pair_word(fr_rdata_r[31:24], sync_word, s1_oob_r);
    out_build.last_chunk = s1_last_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/palette_framebuffer_scanout_top.sv =====
// palette framebuffer scanout: render row gives 40 chunks at one per cycle while the output
// register is not held, set by the single 32-bit read port of the front store.
// a pixel write is a back store read, then a write; clear and present take one store word
// per cycle through all 9600 words. reset: a pass over the 9600 words zeroes the front store
// with in_ready low (config writes still taken); the back store is undefined until written.
// top level: config registers, front end, command queue and engine; uses pfb_pkg
`default_nettype none

module palette_framebuffer_scanout_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pfb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pfb_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import pfb_pkg::*;

  localparam logic REG_OFFSET_Y  = 1'b0;
  localparam logic REG_SYNC_WORD = 1'b1;

  logic signed [9:0] offset_y_r;
  logic [31:0]       sync_word_r;
  logic              cfg_wr;

  logic              fq_valid, fq_ready;
  cmd_t              fq_cmd;
  logic              cmd_valid, cmd_ready;
  cmd_t              cmd;
  logic              init_busy;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_y_r  <= '0;
      sync_word_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_OFFSET_Y:  offset_y_r  <= cfg_pwdata[9:0];
        REG_SYNC_WORD: sync_word_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_OFFSET_Y:  cfg_prdata = {{22{offset_y_r[9]}}, offset_y_r};
      REG_SYNC_WORD: cfg_prdata = sync_word_r;
      default:       cfg_prdata = '0;
    endcase
  end

  pfb_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .offset_y  (offset_y_r),
    .init_busy (init_busy),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  pfb_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_cmd),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_data   (cmd)
  );

  pfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .sync_word (sync_word_r),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no input transfer while the front store is being zeroed
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !init_busy)
    else $error("input taken during front store init");

  // results only appear once init is done
  a_no_out_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !init_busy)
    else $error("result during front store init");

  // the engine is not ready again in the cycle after it takes a command
  a_engine_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("engine took two commands back to back");

endmodule

`default_nettype wire

// ===== bench/pfb_scan_checker.sv =====
`timescale 1ns / 1ps
// row chunk checker for palette_framebuffer_scanout_top: mirrors both pixel stores and the
// registers, queues the chunks each render should give and compares them; uses pfb_pkg
module pfb_scan_checker #(
  parameter logic [2:0] OFFSET_ADDR = 3'd0,
  parameter logic [2:0] SYNC_ADDR   = 3'd4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  pfb_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  pfb_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic          cfg_pready,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output int            chunks_due,
  output int            fail_count
);
  import pfb_pkg::*;

  localparam int STORE_BYTES = FRAME_ROWS * ROW_BYTES;
  // 14-bit colours, index 15 in the top slot
  localparam logic [16*14-1:0] PALETTE = {
    14'h2ab5, 14'h35cf, 14'h23b5, 14'h2210, 14'h154a, 14'h19d7, 14'h010b, 14'h0972,
    14'h1f7a, 14'h28c7, 14'h12ad, 14'h2911, 14'h32ef, 14'h0d11, 14'h3fff, 14'h0000
  };

  logic [7:0]        back_px  [STORE_BYTES];
  logic [7:0]        front_px [STORE_BYTES];
  logic signed [9:0] row_shift;
  logic [31:0]       sync_bits;
  out_t              chunk_q [$];
  out_t              want;
  int                due   = 0;
  int                fails = 0;

  assign chunks_due = due;
  assign fail_count = fails;

  function automatic logic [31:0] pixel_pair(input logic [7:0] b);
    return sync_bits | {2'b00, PALETTE[b[7:4] * 14 +: 14], 2'b00, PALETTE[b[3:0] * 14 +: 14]};
  endfunction

  task automatic apply_item(input in_t it);
    int          pos;
    int          srow;
    int          row;
    logic [31:0] word [4];
    out_t        c;
    case (it.action)
      ACT_WRITE: begin
        if (it.pixel_x < FRAME_COLS && it.pixel_y < FRAME_ROWS) begin
          pos = it.pixel_y * ROW_BYTES + it.pixel_x / 2;
          // even column in the low nibble so writes match scanout order
          if (it.pixel_x[0]) back_px[pos][7:4] = it.color_index;
          else back_px[pos][3:0] = it.color_index;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) back_px[i] = 8'h00;
      end
      ACT_PRESENT: begin
        for (int i = 0; i < STORE_BYTES; i++) front_px[i] = back_px[i];
      end
      ACT_RENDER: begin
        srow = it.scan_row;
        row  = srow - row_shift;
        for (int k = 0; k < CHUNKS; k++) begin
          for (int w = 0; w < 4; w++) begin
            if (row < 0 || row >= FRAME_ROWS) word[w] = sync_bits;
            else word[w] = pixel_pair(front_px[row * ROW_BYTES + k * 4 + w]);
          end
          c.word0      = word[0];
          c.word1      = word[1];
          c.word2      = word[2];
          c.word3      = word[3];
          c.last_chunk = (k == CHUNKS - 1);
          chunk_q.push_back(c);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: chunk %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        back_px[i]  = 8'h00;
        front_px[i] = 8'h00;
      end
      row_shift = '0;
      sync_bits = '0;
      chunk_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (chunk_q.size() == 0) begin
          $display("%0t: chunk with none expected, expected nothing, got %h", $time, out_data);
          fails++;
        end else begin
          want = chunk_q.pop_front();
          check_field("word0", want.word0, out_data.word0);
          check_field("word1", want.word1, out_data.word1);
          check_field("word2", want.word2, out_data.word2);
          check_field("word3", want.word3, out_data.word3);
          check_field("last_chunk", 32'(want.last_chunk), 32'(out_data.last_chunk));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == OFFSET_ADDR) row_shift = cfg_pwdata[9:0];
        else if (cfg_paddr == SYNC_ADDR) sync_bits = cfg_pwdata;
      end
      if (in_valid && in_ready) apply_item(in_data);
    end
    due = chunk_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// testbench top for palette_framebuffer_scanout_top: clock, reset, stimulus and verdict
// depends on pfb_pkg and on pfb_scan_checker, which predicts and compares row chunks
module tb;
  import pfb_pkg::*;

  localparam logic [2:0] REG_OFFSET_Y  = 3'd0;
  localparam logic [2:0] REG_SYNC_WORD = 3'd4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 12;
  localparam int SCAN_MAX      = 1023;
  localparam int IDLE_LIMIT    = 60000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          chunks_due;
  int          fail_count;
  int          cur_offset = 0;
  bit          quiet_in   = 1'b0;
  int          idle_cycles = 0;

  palette_framebuffer_scanout_top uut (.*);

  pfb_scan_checker #(
    .OFFSET_ADDR(REG_OFFSET_Y),
    .SYNC_ADDR  (REG_SYNC_WORD)
  ) u_checker (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t noise_item();
    in_t it;
    it.action      = 2'($urandom_range(0, 3));
    it.pixel_x     = 9'($urandom);
    it.pixel_y     = 9'($urandom);
    it.color_index = 4'($urandom);
    it.scan_row    = 10'($urandom);
    return it;
  endfunction

  function automatic in_t op_item(input logic [1:0] act);
    in_t it;
    it = noise_item();
    it.action = act;
    return it;
  endfunction

  function automatic in_t pixel_item(input int x, input int y, input int c);
    in_t it;
    it = op_item(ACT_WRITE);
    it.pixel_x     = 9'(x);
    it.pixel_y     = 9'(y);
    it.color_index = 4'(c);
    return it;
  endfunction

  // aim at a frame row under the current offset; unreachable rows get a random scan row
  function automatic in_t render_item(input int frame_row);
    in_t it;
    int  scan;
    it = op_item(ACT_RENDER);
    scan = frame_row + cur_offset;
    if (scan >= 0 && scan <= SCAN_MAX) it.scan_row = 10'(scan);
    return it;
  endfunction

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_config(input int offs, input logic [31:0] sync);
    cur_offset = offs;
    cfg_write(REG_OFFSET_Y, 32'(offs));
    cfg_write(REG_SYNC_WORD, sync);
  endtask

  task automatic send(input in_t it);
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    g = quiet_in ? 0 : pause_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // hold off until every queued chunk has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (chunks_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : sink
    int run;
    int hold;
    out_ready = 1'b0;
    forever begin
      run  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      hold = pause_len();
      @(negedge clk);
      out_ready = 1'b1;
      repeat (run) @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_t it;
    int  r;
    int  k;
    int  hot [3];
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: nibble order, frame corners, ignored writes, double buffering, row limits
    set_config(3, 32'hc000_c000);
    send(op_item(ACT_CLEAR));
    send(pixel_item(0, 0, 15));
    send(pixel_item(1, 0, 1));
    send(pixel_item(2, 0, 2));
    send(pixel_item(3, 0, 0));
    send(pixel_item(FRAME_COLS - 1, FRAME_ROWS - 1, 9));
    send(pixel_item(FRAME_COLS - 2, FRAME_ROWS - 1, 14));
    send(pixel_item(FRAME_COLS, 5, 5));
    send(pixel_item(5, FRAME_ROWS, 5));
    send(pixel_item(511, 511, 7));
    send(render_item(0));
    send(op_item(ACT_PRESENT));
    send(render_item(0));
    send(render_item(FRAME_ROWS - 1));
    send(render_item(FRAME_ROWS));
    send(render_item(-3));
    send(render_item(SCAN_MAX - 3));
    send(op_item(ACT_CLEAR));
    send(pixel_item(4, 0, 11));
    send(render_item(0));
    send(op_item(ACT_PRESENT));
    send(render_item(0));
    drain();

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      case (p)
        1: set_config(-512, 32'hffff_ffff);
        2: set_config(511, 32'h0000_0000);
        3: set_config(int'($urandom_range(0, 1023)) - 512, $urandom);
        default: set_config(int'($urandom_range(0, 60)) - 30, $urandom & 32'hc000_c000);
      endcase
      quiet_in = (p == 3);
      // writes and renders crowd onto a few rows so rendered chunks carry pixels
      hot[0] = p[0] ? 0 : FRAME_ROWS - 1;
      hot[1] = $urandom_range(0, FRAME_ROWS - 1);
      hot[2] = $urandom_range(0, FRAME_ROWS - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r  = $urandom_range(0, 99);
        it = noise_item();
        if (r < 55) begin
          it.action = ACT_WRITE;
          if ($urandom_range(0, 4) != 0) begin
            it.pixel_x = 9'($urandom_range(0, FRAME_COLS - 1));
            it.pixel_y = 9'(hot[$urandom_range(0, 2)]);
          end
        end else if (r < 80) begin
          k = $urandom_range(0, 9);
          if (k < 7) begin
            it = render_item(hot[$urandom_range(0, 2)]);
          end else if (k < 9) begin
            // rows just outside and just inside the frame edges
            k = $urandom_range(0, 4);
            it = render_item((k < 2) ? k - 2 : FRAME_ROWS - 3 + k);
          end else begin
            it.action = ACT_RENDER;
          end
        end else if (r < 95) begin
          it.action = ACT_PRESENT;
        end else begin
          it.action = ACT_CLEAR;
        end
        send(it);
      end
      send(render_item(hot[0]));
      drain();
    end
    quiet_in = 1'b0;

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
